/* design/tc_pkg.sv */
`timescale 1ns / 1ps

package tc_pkg;

    // Coordinate format and the widths that follow from it
    localparam int COORD_W  = 32;
    localparam int OFF_W    = COORD_W + 1;          // offset from point a
    localparam int PROD_W   = 2 * OFF_W;            // product of two offsets
    localparam int DET_W    = PROD_W + 1;           // determinant, signed
    localparam int D_W      = DET_W;                // d = 2*det, unsigned when positive
    localparam int SQ_W     = 2 * COORD_W;          // squared offset
    localparam int LEN_W    = SQ_W + 1;             // squared length
    localparam int LLO_W    = OFF_W;                // low slice of a squared length
    localparam int LHI_W    = LEN_W - LLO_W;        // high slice of a squared length
    localparam int PPLO_W   = OFF_W + LLO_W + 1;    // partial product, low slice
    localparam int PPHI_W   = OFF_W + LHI_W + 1;    // partial product, high slice
    localparam int NUM_W    = 3 * COORD_W + 3;      // centre numerator, signed
    localparam int MAG_W    = NUM_W - 1;            // numerator magnitude
    localparam int SQM_W    = 2 * (COORD_W - 1);    // square of a fitting quotient
    localparam int RSQ_W    = 2 * COORD_W;          // radius squared, padded to even
    localparam int REM_W    = COORD_W + 2;          // square root remainder

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-2:0] RAD_MAX   = {(COORD_W-1){1'b1}};

    // Input item: three points
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
    } pts_t;

    // Result item
    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [COORD_W-2:0] radius;
        logic                      overflow;
    } circ_t;

    // Point a and the offsets of b and c from it
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [OFF_W-1:0]   bx;
        logic signed [OFF_W-1:0]   by;
        logic signed [OFF_W-1:0]   cx;
        logic signed [OFF_W-1:0]   cy;
    } off_t;

    // Classified triangle held in the queue
    typedef struct packed {
        off_t           off;
        logic [D_W-1:0] d;
        logic           found;
    } entry_t;

    // Divider input
    typedef struct packed {
        logic [MAG_W-1:0]          mag_x;
        logic [MAG_W-1:0]          mag_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      big_x;
        logic                      big_y;
        logic [D_W-1:0]            d;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic                      found;
    } div_in_t;

    // Divider output
    typedef struct packed {
        logic [COORD_W-1:0]        q_x;
        logic [COORD_W-1:0]        q_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      big_x;
        logic                      big_y;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic                      found;
    } div_out_t;

    // Centre result travelling alongside the square root
    typedef struct packed {
        logic                      found;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic                      ovf;
        logic                      fit;
    } side_t;

endpackage

/* design/triangle_circumcircle.sv */
`timescale 1ns / 1ps

// Circumcircle of three points in signed Q16.16. One triangle is taken per clock
// while the queue has room, and one result leaves per clock in steady flow while
// the output is taken. The pipelined restoring divider and square root each
// produce one bit per stage. The front forms offsets and the determinant and
// sorts triangles into found or not found; a queue of QUEUE_DEPTH items lets
// the front keep taking items while the back is held by a stalled output.
// Collinear or clockwise triangles give found = 0 with all other fields zero.
module triangle_circumcircle import tc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  pts_t  pts,
    input  logic  pts_valid,
    output logic  pts_ready,
    output circ_t circ,
    output logic  circ_valid,
    input  logic  circ_ready
);

    logic               en;
    logic               push;
    entry_t             push_data;
    entry_t             head;
    logic               q_full;
    logic               q_empty;
    div_in_t            dv;
    logic               dv_valid;
    div_out_t           qo;
    logic               qo_valid;

    side_t              p1_side_reg;
    side_t              p1_side_next;
    logic [SQM_W-1:0]   sq_x_reg;
    logic [SQM_W-1:0]   sq_y_reg;
    logic               p1_valid_reg;
    side_t              p2_side_reg;
    logic [RSQ_W-1:0]   p2_rsq_reg;
    logic               p2_valid_reg;

    logic [COORD_W-1:0] root;
    side_t              root_side;
    logic               root_valid;

    circ_t              out_reg;
    circ_t              out_next;
    logic               out_valid_reg;

    logic [COORD_W:0]   place_x;
    logic [COORD_W:0]   place_y;

    // Centre coordinate a + q with saturation; the top bit flags overflow
    function automatic logic [COORD_W:0] place(
        input logic signed [COORD_W-1:0] a,
        input logic        [COORD_W-1:0] q,
        input logic                      neg,
        input logic                      big
    );
        logic signed [COORD_W+1:0] qs;
        logic signed [COORD_W+1:0] s;
        qs = $signed({2'b00, q});
        s  = $signed({{2{a[COORD_W-1]}}, a}) + (neg ? -qs : qs);
        if (big)
            return {1'b1, neg ? COORD_MIN : COORD_MAX};
        else if (s[COORD_W+1:COORD_W-1] == 3'b000 || s[COORD_W+1:COORD_W-1] == 3'b111)
            return {1'b0, s[COORD_W-1:0]};
        else
            return {1'b1, s[COORD_W+1] ? COORD_MIN : COORD_MAX};
    endfunction

    // Back end moves only while the output register can take a result
    assign en = !out_valid_reg || circ_ready;

    tc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pts       (pts),
        .pts_valid (pts_valid),
        .pts_ready (pts_ready),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    tc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (en && !q_empty),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tc_numer u_numer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .head       (head),
        .head_valid (!q_empty),
        .dv         (dv),
        .dv_valid   (dv_valid)
    );

    tc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .dv       (dv),
        .dv_valid (dv_valid),
        .qo       (qo),
        .qo_valid (qo_valid)
    );

    // Centre placement and radius operand check
    assign place_x = place(qo.a_x, qo.q_x, qo.neg_x, qo.big_x);
    assign place_y = place(qo.a_y, qo.q_y, qo.neg_y, qo.big_y);

    always_comb
    begin
        p1_side_next.found    = qo.found;
        p1_side_next.center_x = place_x[COORD_W-1:0];
        p1_side_next.center_y = place_y[COORD_W-1:0];
        p1_side_next.ovf      = place_x[COORD_W] | place_y[COORD_W];
        p1_side_next.fit      = !qo.big_x && !qo.q_x[COORD_W-1] &&
                                !qo.big_y && !qo.q_y[COORD_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= qo_valid;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_side_reg <= p1_side_next;
            sq_x_reg    <= SQM_W'(qo.q_x[COORD_W-2:0]) * SQM_W'(qo.q_x[COORD_W-2:0]);
            sq_y_reg    <= SQM_W'(qo.q_y[COORD_W-2:0]) * SQM_W'(qo.q_y[COORD_W-2:0]);
            p2_side_reg <= p1_side_reg;
            p2_rsq_reg  <= RSQ_W'(sq_x_reg) + RSQ_W'(sq_y_reg);
            out_reg     <= out_next;
        end
    end

    tc_sqrt u_sqrt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .rsq        (p2_rsq_reg),
        .side_in    (p2_side_reg),
        .rsq_valid  (p2_valid_reg),
        .root       (root),
        .side_out   (root_side),
        .root_valid (root_valid)
    );

    // Final result: radius saturation, and zeroes when no circle
    always_comb
    begin
        out_next = '0;
        if (root_side.found)
        begin
            out_next.found    = 1'b1;
            out_next.center_x = root_side.center_x;
            out_next.center_y = root_side.center_y;
            out_next.radius   = (!root_side.fit || root[COORD_W-1]) ?
                                RAD_MAX : root[COORD_W-2:0];
            out_next.overflow = root_side.ovf || !root_side.fit || root[COORD_W-1];
        end
    end

    assign circ       = out_reg;
    assign circ_valid = out_valid_reg;

endmodule

/* design/tc_front.sv */
`timescale 1ns / 1ps

module tc_front import tc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  pts_t   pts,
    input  logic   pts_valid,
    output logic   pts_ready,
    input  logic   q_full,
    output logic   push,
    output entry_t push_data
);

    logic                      en;
    off_t                      s1_reg;
    off_t                      s1_next;
    logic                      s1_valid_reg;
    off_t                      s2_reg;
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  p_bc_reg;
    logic signed [PROD_W-1:0]  p_bc_next;
    logic signed [PROD_W-1:0]  p_cb_reg;
    logic signed [PROD_W-1:0]  p_cb_next;
    logic signed [DET_W-1:0]   det;

    // Whole front advances while the queue has room
    assign en        = !q_full;
    assign pts_ready = en;

    // Offsets from point a
    always_comb
    begin
        s1_next.a_x = pts.a_x;
        s1_next.a_y = pts.a_y;
        s1_next.bx  = OFF_W'(pts.b_x) - OFF_W'(pts.a_x);
        s1_next.by  = OFF_W'(pts.b_y) - OFF_W'(pts.a_y);
        s1_next.cx  = OFF_W'(pts.c_x) - OFF_W'(pts.a_x);
        s1_next.cy  = OFF_W'(pts.c_y) - OFF_W'(pts.a_y);
    end

    // Cross products
    assign p_bc_next = PROD_W'(s1_reg.bx) * PROD_W'(s1_reg.cy);
    assign p_cb_next = PROD_W'(s1_reg.by) * PROD_W'(s1_reg.cx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pts_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            p_bc_reg <= p_bc_next;
            p_cb_reg <= p_cb_next;
        end
    end

    // Classify: a circle exists only for a positive determinant
    assign det = DET_W'(p_bc_reg) - DET_W'(p_cb_reg);

    always_comb
    begin
        push_data.off   = s2_reg;
        push_data.d     = {det[DET_W-2:0], 1'b0};
        push_data.found = !det[DET_W-1] && (det != '0);
    end

    assign push = en && s2_valid_reg;

endmodule

/* design/tc_queue.sv */
`timescale 1ns / 1ps

module tc_queue import tc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t head,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* design/tc_numer.sv */
`timescale 1ns / 1ps

module tc_numer import tc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  entry_t  head,
    input  logic    head_valid,
    output div_in_t dv,
    output logic    dv_valid
);

    logic [5:0]               valid_reg;

    // Stage 1: squared offsets
    entry_t                   e1_reg;
    logic [SQ_W-1:0]          sq_bx_reg, sq_by_reg, sq_cx_reg, sq_cy_reg;
    logic signed [PROD_W-1:0] sq_bx_next, sq_by_next, sq_cx_next, sq_cy_next;

    // Stage 2: squared lengths
    entry_t                   e2_reg;
    logic [LEN_W-1:0]         l1_reg, l2_reg;

    // Stage 3: sliced partial products
    entry_t                   e3_reg;
    logic signed [PPLO_W-1:0] cy_l1_lo_reg, by_l2_lo_reg, bx_l2_lo_reg, cx_l1_lo_reg;
    logic signed [PPHI_W-1:0] cy_l1_hi_reg, by_l2_hi_reg, bx_l2_hi_reg, cx_l1_hi_reg;

    // Stage 4: full products
    entry_t                   e4_reg;
    logic signed [NUM_W-1:0]  cy_l1_reg, by_l2_reg, bx_l2_reg, cx_l1_reg;

    // Stage 5: numerators
    entry_t                   e5_reg;
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;

    // Stage 6: magnitudes and range check
    div_in_t                  dv_reg;
    div_in_t                  dv_next;

    assign sq_bx_next = PROD_W'(head.off.bx) * PROD_W'(head.off.bx);
    assign sq_by_next = PROD_W'(head.off.by) * PROD_W'(head.off.by);
    assign sq_cx_next = PROD_W'(head.off.cx) * PROD_W'(head.off.cx);
    assign sq_cy_next = PROD_W'(head.off.cy) * PROD_W'(head.off.cy);

    // A quotient wider than COORD_W bits only saturates
    always_comb
    begin
        dv_next.neg_x = nx_reg[NUM_W-1];
        dv_next.neg_y = ny_reg[NUM_W-1];
        dv_next.mag_x = nx_reg[NUM_W-1] ? MAG_W'(-nx_reg) : MAG_W'(nx_reg);
        dv_next.mag_y = ny_reg[NUM_W-1] ? MAG_W'(-ny_reg) : MAG_W'(ny_reg);
        dv_next.big_x = D_W'(dv_next.mag_x[MAG_W-1:COORD_W]) >= e5_reg.d;
        dv_next.big_y = D_W'(dv_next.mag_y[MAG_W-1:COORD_W]) >= e5_reg.d;
        dv_next.d     = e5_reg.d;
        dv_next.a_x   = e5_reg.off.a_x;
        dv_next.a_y   = e5_reg.off.a_y;
        dv_next.found = e5_reg.found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[4:0], head_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg    <= head;
            sq_bx_reg <= sq_bx_next[SQ_W-1:0];
            sq_by_reg <= sq_by_next[SQ_W-1:0];
            sq_cx_reg <= sq_cx_next[SQ_W-1:0];
            sq_cy_reg <= sq_cy_next[SQ_W-1:0];

            e2_reg <= e1_reg;
            l1_reg <= LEN_W'(sq_bx_reg) + LEN_W'(sq_by_reg);
            l2_reg <= LEN_W'(sq_cx_reg) + LEN_W'(sq_cy_reg);

            e3_reg       <= e2_reg;
            cy_l1_lo_reg <= PPLO_W'(e2_reg.off.cy) * $signed(PPLO_W'(l1_reg[LLO_W-1:0]));
            by_l2_lo_reg <= PPLO_W'(e2_reg.off.by) * $signed(PPLO_W'(l2_reg[LLO_W-1:0]));
            bx_l2_lo_reg <= PPLO_W'(e2_reg.off.bx) * $signed(PPLO_W'(l2_reg[LLO_W-1:0]));
            cx_l1_lo_reg <= PPLO_W'(e2_reg.off.cx) * $signed(PPLO_W'(l1_reg[LLO_W-1:0]));
            cy_l1_hi_reg <= PPHI_W'(e2_reg.off.cy) * $signed(PPHI_W'(l1_reg[LEN_W-1:LLO_W]));
            by_l2_hi_reg <= PPHI_W'(e2_reg.off.by) * $signed(PPHI_W'(l2_reg[LEN_W-1:LLO_W]));
            bx_l2_hi_reg <= PPHI_W'(e2_reg.off.bx) * $signed(PPHI_W'(l2_reg[LEN_W-1:LLO_W]));
            cx_l1_hi_reg <= PPHI_W'(e2_reg.off.cx) * $signed(PPHI_W'(l1_reg[LEN_W-1:LLO_W]));

            e4_reg    <= e3_reg;
            cy_l1_reg <= (NUM_W'(cy_l1_hi_reg) <<< LLO_W) + NUM_W'(cy_l1_lo_reg);
            by_l2_reg <= (NUM_W'(by_l2_hi_reg) <<< LLO_W) + NUM_W'(by_l2_lo_reg);
            bx_l2_reg <= (NUM_W'(bx_l2_hi_reg) <<< LLO_W) + NUM_W'(bx_l2_lo_reg);
            cx_l1_reg <= (NUM_W'(cx_l1_hi_reg) <<< LLO_W) + NUM_W'(cx_l1_lo_reg);

            e5_reg <= e4_reg;
            nx_reg <= cy_l1_reg - by_l2_reg;
            ny_reg <= bx_l2_reg - cx_l1_reg;

            dv_reg <= dv_next;
        end
    end

    assign dv       = dv_reg;
    assign dv_valid = valid_reg[5];

endmodule

/* design/tc_div.sv */
`timescale 1ns / 1ps

module tc_div import tc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  div_in_t  dv,
    input  logic     dv_valid,
    output div_out_t qo,
    output logic     qo_valid
);

    typedef struct packed {
        logic [D_W-1:0]     rem;
        logic [COORD_W-1:0] low;
        logic [COORD_W-1:0] q;
    } lane_t;

    typedef struct packed {
        lane_t                     x;
        lane_t                     y;
        logic [D_W-1:0]            d;
        logic                      neg_x;
        logic                      neg_y;
        logic                      big_x;
        logic                      big_y;
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic                      found;
    } dstage_t;

    // One restoring step: bring down a numerator bit, subtract d if it fits
    function automatic lane_t lane_step(input lane_t l, input logic [D_W-1:0] d);
        logic [D_W:0] t;
        lane_t        r;
        t     = {l.rem, l.low[COORD_W-1]};
        r.low = l.low << 1;
        if (t >= {1'b0, d})
        begin
            r.rem = D_W'(t - {1'b0, d});
            r.q   = {l.q[COORD_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[D_W-1:0];
            r.q   = {l.q[COORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

    dstage_t            first;
    dstage_t            st_reg [COORD_W];
    logic [COORD_W-1:0] valid_reg;

    // High part of the numerator is the starting remainder
    always_comb
    begin
        first.x.rem = D_W'(dv.mag_x[MAG_W-1:COORD_W]);
        first.x.low = dv.mag_x[COORD_W-1:0];
        first.x.q   = '0;
        first.y.rem = D_W'(dv.mag_y[MAG_W-1:COORD_W]);
        first.y.low = dv.mag_y[COORD_W-1:0];
        first.y.q   = '0;
        first.d     = dv.d;
        first.neg_x = dv.neg_x;
        first.neg_y = dv.neg_y;
        first.big_x = dv.big_x;
        first.big_y = dv.big_y;
        first.a_x   = dv.a_x;
        first.a_y   = dv.a_y;
        first.found = dv.found;
    end

    // One quotient bit per stage for both coordinates
    for (genvar k = 0; k < COORD_W; k++)
    begin : g_stage
        dstage_t cur;
        dstage_t nxt;

        if (k == 0)
        begin : g_first
            assign cur = first;
        end
        else
        begin : g_rest
            assign cur = st_reg[k-1];
        end

        always_comb
        begin
            nxt   = cur;
            nxt.x = lane_step(cur.x, cur.d);
            nxt.y = lane_step(cur.y, cur.d);
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[COORD_W-2:0], dv_valid};
    end

    always_comb
    begin
        qo.q_x   = st_reg[COORD_W-1].x.q;
        qo.q_y   = st_reg[COORD_W-1].y.q;
        qo.neg_x = st_reg[COORD_W-1].neg_x;
        qo.neg_y = st_reg[COORD_W-1].neg_y;
        qo.big_x = st_reg[COORD_W-1].big_x;
        qo.big_y = st_reg[COORD_W-1].big_y;
        qo.a_x   = st_reg[COORD_W-1].a_x;
        qo.a_y   = st_reg[COORD_W-1].a_y;
        qo.found = st_reg[COORD_W-1].found;
    end

    assign qo_valid = valid_reg[COORD_W-1];

endmodule

/* design/tc_sqrt.sv */
`timescale 1ns / 1ps

module tc_sqrt import tc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [RSQ_W-1:0]   rsq,
    input  side_t              side_in,
    input  logic               rsq_valid,
    output logic [COORD_W-1:0] root,
    output side_t              side_out,
    output logic               root_valid
);

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [COORD_W-1:0] root;
        logic [RSQ_W-1:0]   n;
        side_t              side;
    } sstage_t;

    sstage_t            first;
    sstage_t            st_reg [COORD_W];
    logic [COORD_W-1:0] valid_reg;

    always_comb
    begin
        first.rem  = '0;
        first.root = '0;
        first.n    = rsq;
        first.side = side_in;
    end

    // One root bit per stage, two radicand bits brought down each time
    for (genvar k = 0; k < COORD_W; k++)
    begin : g_stage
        sstage_t          cur;
        sstage_t          nxt;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign cur = first;
        end
        else
        begin : g_rest
            assign cur = st_reg[k-1];
        end

        assign t     = {cur.rem[REM_W-3:0], cur.n[RSQ_W-1:RSQ_W-2]};
        assign trial = {cur.root, 2'b01};

        always_comb
        begin
            nxt   = cur;
            nxt.n = cur.n << 2;
            if (t >= trial)
            begin
                nxt.rem  = t - trial;
                nxt.root = {cur.root[COORD_W-2:0], 1'b1};
            end
            else
            begin
                nxt.rem  = t;
                nxt.root = {cur.root[COORD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg[k] <= nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[COORD_W-2:0], rsq_valid};
    end

    assign root       = st_reg[COORD_W-1].root;
    assign side_out   = st_reg[COORD_W-1].side;
    assign root_valid = valid_reg[COORD_W-1];

endmodule
